// ===== hw/rtl/msc_pkg.sv =====
// Shared types, constants and helper functions of the motion scenario classifier.
// No dependencies; the classifier core imports this package.
`default_nettype none
package msc_pkg;

  localparam int WIN      = 60;              // speeds kept in the window
  localparam int SLOT_W   = $clog2(WIN);
  localparam int SPD_W    = 12;
  localparam int SUM_W    = 18;              // WIN * 4095 fits
  localparam int SQ_W     = 30;              // WIN * 4095^2 fits
  localparam int DEV_W    = 36;              // WIN*sq - sum^2 and threshold squares
  localparam int DROOT_W  = DEV_W / 2;
  localparam int PSQ_W    = 64;
  localparam int PROOT_W  = PSQ_W / 2;
  localparam int DELTA_W  = 31;
  localparam int PATH_W   = 48;
  localparam int CNT_W    = 5;
  localparam int NREG     = 7;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 120;

  localparam logic [2:0] REG_STILL_SPEED  = 3'd0;
  localparam logic [2:0] REG_STILL_SPREAD = 3'd1;
  localparam logic [2:0] REG_FAST_SPEED   = 3'd2;
  localparam logic [2:0] REG_FAST_SPREAD  = 3'd3;
  localparam logic [2:0] REG_TOWN_SPEED   = 3'd4;
  localparam logic [2:0] REG_TOWN_SPREAD  = 3'd5;
  localparam logic [2:0] REG_CRAWL_SPEED  = 3'd6;

  localparam logic [2:0] SC_STILL = 3'd0;
  localparam logic [2:0] SC_SLOW  = 3'd1;
  localparam logic [2:0] SC_FAST  = 3'd2;
  localparam logic [2:0] SC_TOWN  = 3'd3;
  localparam logic [2:0] SC_NONE  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_DEV, ST_ROOT, ST_DIV, ST_FIN
  } state_t;

  function automatic logic [SPD_W-1:0] reg_reset(input logic [2:0] idx);
    case (idx)
      REG_STILL_SPEED:  return 12'd50;
      REG_STILL_SPREAD: return 12'd30;
      REG_FAST_SPEED:   return 12'd500;
      REG_FAST_SPREAD:  return 12'd150;
      REG_TOWN_SPEED:   return 12'd100;
      REG_TOWN_SPREAD:  return 12'd100;
      REG_CRAWL_SPEED:  return 12'd250;
      default:          return 12'd0;
    endcase
  endfunction

  function automatic logic [7:0] rate_of(input logic [2:0] sc);
    case (sc)
      SC_STILL: return 8'd64;
      SC_SLOW:  return 8'd128;
      SC_FAST:  return 8'd150;
      SC_TOWN:  return 8'd180;
      default:  return 8'd128;
    endcase
  endfunction

  // Magnitude of a position step, saturated to 2^31-1.
  function automatic logic [DELTA_W-1:0] clamp_abs(input logic signed [32:0] d);
    logic signed [32:0] m;
    m = d[32] ? -d : d;
    if (m > 33'sd2147483647) return 31'h7FFF_FFFF;
    return m[DELTA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/msc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/motion_scenario_classifier_core.sv =====
// Motion scenario classifier: sequencer, bit-serial roots and dividers, output register.
// Depends on msc_pkg and msc_ram.
//
// Usage: one position fix enters per in_ transaction on in_tdata; exactly one result
// leaves per out_ transaction on out_tdata. The speed window lives in a 60-entry RAM
// whose entries read as zero until written, tracked by one valid bit per entry.
// Each fix runs through a sequence of steps: the window sums are updated and the position
// steps squared, the variance products are formed, one subtract follows, then the path
// step root, the deviation root and the mean division run side by side, each giving one
// bit per cycle, then the deviation root is divided by the window length one bit per
// cycle, and last the result is classified and loaded. The result is loaded into the
// output register on the same edge that returns the sequencer to idle, so in_tready
// rises again together with out_tvalid; a new fix is accepted only once the previous
// one has been loaded.
// The output register lets the next fix be accepted and processed while the previous
// result waits; if the receiver still stalls when the next result is complete, the
// sequencer holds that result until the output register is free.
// Reset (rst_n low, synchronous) restores the threshold registers to their defaults,
// empties the window, clears the path and change counters and drops out_tvalid.
// Configuration writes are always accepted (cfg_ready is high); an index above six is
// ignored.
`default_nettype none
module motion_scenario_classifier_core (
  input  wire                     clk,
  input  wire                     rst_n,
  // in_tdata: speed [11:0], latitude [42:12], longitude [74:43], zero pad [79:75]
  input  wire [msc_pkg::IN_W-1:0] in_tdata,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  // out_tdata: scenario [2:0], changed [3], mean_speed [15:4], speed_spread [27:16],
  // suggested_rate [35:28], path_length [83:36], change_count [115:84], zero [119:116]
  output logic [msc_pkg::OUT_W-1:0] out_tdata,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [2:0]               cfg_index,
  input  wire [11:0]              cfg_data
);
  import msc_pkg::*;

  state_t state_r, state_nxt;

  logic [SPD_W-1:0]    cfg_r [NREG];
  logic [SPD_W-1:0]    spd_r;
  logic [DELTA_W-1:0]  da_r, db_r;
  logic                first_r;
  logic signed [30:0]  last_lat_r;
  logic signed [31:0]  last_lon_r;
  logic                have_last_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [WIN-1:0]      valid_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]     sq_r;
  logic [61:0]         a2_r, b2_r;
  logic [DEV_W-1:0]    ssq_r, sq60_r, dv_r, tsq_r;
  logic [PSQ_W-1:0]    pv_r;
  logic [PROOT_W+1:0]  prem_r;
  logic [PROOT_W-1:0]  proot_r;
  logic [DEV_W-1:0]    dvs_r;
  logic [DROOT_W+1:0]  drem_r;
  logic [DROOT_W-1:0]  droot_r;
  logic [SUM_W-1:0]    mx_r, qx_r;
  logic [5:0]          mrem_r, qrem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                f_st_r, f_fa_r, f_to_r;
  logic [PATH_W-1:0]   path_r;
  logic [2:0]          cur_r;
  logic [31:0]         chg_cnt_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                in_acc, fin_go;
  logic [SPD_W-1:0]    rd_data, old_spd;
  logic [SUM_W-1:0]    st_s, fa_s, to_s, cr_s, thr_s;
  logic [SPD_W-1:0]    thr_sel;
  logic [2:0]          scen;
  logic                chg;
  logic [PROOT_W+1:0]  p_t, p_trial;
  logic [DROOT_W+1:0]  d_t, d_trial;
  logic [6:0]          m_t, q_t;
  logic [PATH_W-1:0]   path_new;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_acc     = in_tvalid && in_tready;
  assign fin_go     = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  msc_ram #(.WIDTH(SPD_W), .DEPTH(WIN)) u_window (
    .clk   (clk),
    .we    (state_r == ST_LOAD),
    .waddr (slot_r),
    .wdata (spd_r),
    .raddr (slot_r),
    .rdata (rd_data)
  );

  assign old_spd = valid_r[slot_r] ? rd_data : '0;

  // Scaled thresholds for the exact comparisons on the window sums.
  assign st_s = SUM_W'(cfg_r[REG_STILL_SPEED] * WIN);
  assign fa_s = SUM_W'(cfg_r[REG_FAST_SPEED] * WIN);
  assign to_s = SUM_W'(cfg_r[REG_TOWN_SPEED] * WIN);
  assign cr_s = SUM_W'(cfg_r[REG_CRAWL_SPEED] * WIN);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    thr_sel = cfg_r[REG_STILL_SPREAD];
      2'd1:    thr_sel = cfg_r[REG_FAST_SPREAD];
      default: thr_sel = cfg_r[REG_TOWN_SPREAD];
    endcase
    thr_s = SUM_W'(thr_sel * WIN);
  end

  // One step of each digit-serial unit.
  assign p_t     = {prem_r[PROOT_W-1:0], pv_r[PSQ_W-1 -: 2]};
  assign p_trial = {proot_r, 2'b01};
  assign d_t     = {drem_r[DROOT_W-1:0], dvs_r[DEV_W-1 -: 2]};
  assign d_trial = {droot_r, 2'b01};
  assign m_t     = {mrem_r, mx_r[SUM_W-1]};
  assign q_t     = {qrem_r, qx_r[SUM_W-1]};

  always_comb begin
    if (sum_r < st_s && f_st_r) begin
      scen = SC_STILL;
    end else if (sum_r > fa_s && f_fa_r) begin
      scen = SC_FAST;
    end else if (sum_r > to_s && sum_r < fa_s && f_to_r) begin
      scen = SC_TOWN;
    end else if (sum_r > st_s && sum_r < cr_s) begin
      scen = SC_SLOW;
    end else begin
      scen = SC_NONE;
    end
    chg      = (scen != cur_r);
    path_new = first_r ? path_r : path_r + PATH_W'(proot_r);
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DEV;
      ST_DEV:  state_nxt = ST_ROOT;
      ST_ROOT: if (cnt_r == CNT_W'(PROOT_W - 1)) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNT_W'(SUM_W - 1)) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) cfg_r[i] <= reg_reset(3'(i));
      have_last_r <= 1'b0;
      last_lat_r  <= '0;
      last_lon_r  <= '0;
      slot_r      <= '0;
      valid_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      path_r      <= '0;
      cur_r       <= SC_STILL;
      chg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index < 3'(NREG)) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (in_acc) begin
        last_lat_r  <= $signed(in_tdata[42:12]);
        last_lon_r  <= $signed(in_tdata[74:43]);
        have_last_r <= 1'b1;
      end
      if (state_r == ST_LOAD) begin
        sum_r <= sum_r - SUM_W'(old_spd) + SUM_W'(spd_r);
        sq_r  <= sq_r - SQ_W'(old_spd * old_spd) + SQ_W'(spd_r * spd_r);
        valid_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == SLOT_W'(WIN - 1)) ? '0 : slot_r + 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_go) begin
        path_r      <= path_new;
        if (chg) begin
          cur_r     <= scen;
          chg_cnt_r <= chg_cnt_r + 32'd1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          spd_r   <= in_tdata[11:0];
          first_r <= !have_last_r;
          da_r    <= clamp_abs(33'(signed'(in_tdata[42:12])) - 33'(last_lat_r));
          db_r    <= clamp_abs(33'(signed'(in_tdata[74:43])) - 33'(last_lon_r));
        end
      end
      ST_LOAD: begin
        a2_r <= 62'(da_r) * 62'(da_r);
        b2_r <= 62'(db_r) * 62'(db_r);
      end
      ST_MUL: begin
        ssq_r  <= DEV_W'(sum_r) * DEV_W'(sum_r);
        sq60_r <= DEV_W'(sq_r) * DEV_W'(WIN);
        pv_r   <= PSQ_W'(a2_r) + PSQ_W'(b2_r);
        mx_r   <= sum_r;
        mrem_r <= '0;
      end
      ST_DEV: begin
        dv_r    <= sq60_r - ssq_r;
        dvs_r   <= sq60_r - ssq_r;
        prem_r  <= '0;
        proot_r <= '0;
        drem_r  <= '0;
        droot_r <= '0;
        cnt_r   <= '0;
      end
      ST_ROOT: begin
        if (p_t >= p_trial) begin
          prem_r  <= p_t - p_trial;
          proot_r <= {proot_r[PROOT_W-2:0], 1'b1};
        end else begin
          prem_r  <= p_t;
          proot_r <= {proot_r[PROOT_W-2:0], 1'b0};
        end
        pv_r <= {pv_r[PSQ_W-3:0], 2'b00};
        if (cnt_r < CNT_W'(DROOT_W)) begin
          if (d_t >= d_trial) begin
            drem_r  <= d_t - d_trial;
            droot_r <= {droot_r[DROOT_W-2:0], 1'b1};
          end else begin
            drem_r  <= d_t;
            droot_r <= {droot_r[DROOT_W-2:0], 1'b0};
          end
          dvs_r <= {dvs_r[DEV_W-3:0], 2'b00};
          if (m_t >= 7'(WIN)) begin
            mrem_r <= 6'(m_t - 7'(WIN));
            mx_r   <= {mx_r[SUM_W-2:0], 1'b1};
          end else begin
            mrem_r <= m_t[5:0];
            mx_r   <= {mx_r[SUM_W-2:0], 1'b0};
          end
        end
        // Threshold squares: one product per cycle, compared in the next.
        if (cnt_r < CNT_W'(3)) begin
          tsq_r <= DEV_W'(thr_s) * DEV_W'(thr_s);
        end
        case (cnt_r)
          CNT_W'(1): f_st_r <= dv_r < tsq_r;
          CNT_W'(2): f_fa_r <= dv_r < tsq_r;
          CNT_W'(3): f_to_r <= dv_r > tsq_r;
          default: ;
        endcase
        if (cnt_r == CNT_W'(PROOT_W - 1)) begin
          cnt_r  <= '0;
          qx_r   <= droot_r;
          qrem_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (q_t >= 7'(WIN)) begin
          qrem_r <= 6'(q_t - 7'(WIN));
          qx_r   <= {qx_r[SUM_W-2:0], 1'b1};
        end else begin
          qrem_r <= q_t[5:0];
          qx_r   <= {qx_r[SUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_data_r <= {4'b0000,
                         chg ? chg_cnt_r + 32'd1 : chg_cnt_r,
                         path_new,
                         rate_of(scen),
                         qx_r[11:0],
                         mx_r[11:0],
                         chg,
                         scen};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
